// ===== rtl/core/tbe_pkg.sv =====
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared types and constants of the three-button emulator.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int BUTTON_COUNT_DEF = 31;
  localparam int BTN_W            = 5;
  localparam int BTN_CMP_W        = 8;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [BTN_W-1:0] FAKE_MIDDLE = 5'd2;
  localparam logic [BTN_W-1:0] BTN_NONE    = 5'd0;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_EMULATE_ENABLE = 1'b0;

  localparam logic ACT_PRESS   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [BTN_W-1:0] button;
    logic             left_held;
    logic             right_held;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic             release_ev;
    logic [BTN_W-1:0] button;
    logic             timer_start;
    logic             timer_cancel;
  } res_t;

  typedef struct packed {
    res_t             r0;
    res_t             r1;
    logic [1:0]       cnt;
    logic [BTN_W-1:0] held;
    logic             fake;
  } dec_t;

endpackage

// ===== rtl/core/tbe_cfg.sv =====
// ----------------------------------------------------------------------------
// tbe_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module tbe_cfg import tbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic                  emulate_enable
);

  logic enable_r;
  logic enable_nxt;
  logic wr_en;
  logic reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    enable_nxt = enable_r;
    if (wr_en && reg_idx == REG_EMULATE_ENABLE) begin
      enable_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_EMULATE_ENABLE) begin
      cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, enable_r};
    end
  end

  assign emulate_enable = enable_r;

endmodule

// ===== rtl/core/tbe_decode.sv =====
// ----------------------------------------------------------------------------
// tbe_decode
// Event rules: turns one button event and the emulation state into up to two
// result words and the next state.
// ----------------------------------------------------------------------------
module tbe_decode import tbe_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  item_t            item,
  input  logic             emulate_enable,
  input  logic [BTN_W-1:0] held,
  input  logic             fake,
  output dec_t             dec
);

  logic [BTN_CMP_W-1:0] btn_ext;
  logic                 in_range;
  logic                 is_rel;

  assign btn_ext  = {{(BTN_CMP_W-BTN_W){1'b0}}, item.button};
  assign in_range = (item.button != BTN_NONE) &&
                    (btn_ext <= BTN_CMP_W'(BUTTON_COUNT));
  assign is_rel   = (item.action == ACT_RELEASE);

  always_comb begin
    dec      = '0;
    dec.held = held;
    dec.fake = fake;
    if (in_range) begin
      if (!emulate_enable) begin
        dec.cnt           = 2'd1;
        dec.r0.valid      = 1'b1;
        dec.r0.release_ev = is_rel;
        dec.r0.button     = item.button;
      end else if (!is_rel && held == BTN_NONE && !fake) begin
        // First press is held back until its partner or its release shows.
        dec.held           = item.button;
        dec.cnt            = 2'd1;
        dec.r0.timer_start = 1'b1;
      end else if (!is_rel && held != BTN_NONE && held != item.button && !fake) begin
        dec.held            = BTN_NONE;
        dec.fake            = 1'b1;
        dec.cnt             = 2'd1;
        dec.r0.valid        = 1'b1;
        dec.r0.button       = FAKE_MIDDLE;
        dec.r0.timer_cancel = 1'b1;
      end else if (is_rel && held == item.button) begin
        dec.held            = BTN_NONE;
        dec.cnt             = 2'd2;
        dec.r0.valid        = 1'b1;
        dec.r0.button       = item.button;
        dec.r0.timer_cancel = 1'b1;
        dec.r1.valid        = 1'b1;
        dec.r1.release_ev   = 1'b1;
        dec.r1.button       = item.button;
      end else if (is_rel && fake && !item.left_held && !item.right_held) begin
        dec.fake          = 1'b0;
        dec.cnt           = 2'd1;
        dec.r0.valid      = 1'b1;
        dec.r0.release_ev = 1'b1;
        dec.r0.button     = FAKE_MIDDLE;
      end else if (is_rel && held == BTN_NONE && !fake) begin
        dec.cnt           = 2'd1;
        dec.r0.valid      = 1'b1;
        dec.r0.release_ev = 1'b1;
        dec.r0.button     = item.button;
      end
    end
  end

endmodule

// ===== rtl/core/three_button_emulator.sv =====
// ----------------------------------------------------------------------------
// three_button_emulator
// Emulates a middle button from chorded left/right presses.
// ----------------------------------------------------------------------------
// Usage: button events enter on the in_ stream, one word per event; the
// emulator answers on the out_ stream with zero, one or two words per event,
// the final one marked by out_tlast. The cfg_ port holds emulate_enable at
// byte address 0; write it only while no event is in flight.
// An accepted event is registered in the input register, decoded
// combinationally, and its first result word loads into the output register.
// An event with two results stays in the input register while the single
// output register takes one word per cycle, when the receiver is not
// stalling. A new event is taken in the cycle its predecessor finishes.
// Reset clears the emulation state (no press held back, no fake middle
// down), empties both registers and turns emulation off.
// When the receiver stalls, the output word holds and the input register
// fills; in_tready then drops until the output register can move again.
// ----------------------------------------------------------------------------
module three_button_emulator import tbe_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [4:0] button, [5] left_held, [6] right_held, [7] zero
  input  logic [7:0]            in_tdata,
  // [0] action
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [4:0] event_button, [5] timer_start, [6] timer_cancel, [7] zero
  output logic [7:0]            out_tdata,
  // [0] event_valid, [1] event_release
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic             emulate_enable;
  logic             in_valid_r;
  item_t            in_item_r;
  logic [BTN_W-1:0] held_r;
  logic             fake_r;
  logic             phase_r;
  logic             phase_nxt;
  logic             out_valid_r;
  res_t             out_res_r;
  logic             out_last_r;
  dec_t             dec;
  res_t             sel;
  logic             out_space;
  logic             last_sel;
  logic             load;
  logic             done;

  tbe_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .emulate_enable (emulate_enable)
  );

  tbe_decode #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_decode (
    .item           (in_item_r),
    .emulate_enable (emulate_enable),
    .held           (held_r),
    .fake           (fake_r),
    .dec            (dec)
  );

  assign out_space = !out_valid_r || out_tready;
  assign last_sel  = phase_r || (dec.cnt == 2'd1);
  assign sel       = phase_r ? dec.r1 : dec.r0;
  assign load      = in_valid_r && (dec.cnt != 2'd0) && out_space;
  // An event finishes when it has no result or its final word is loaded.
  assign done      = in_valid_r && ((dec.cnt == 2'd0) || (out_space && last_sel));
  assign in_tready = !in_valid_r || done;

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = !last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      held_r      <= BTN_NONE;
      fake_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (done) begin
        held_r <= dec.held;
        fake_r <= dec.fake;
      end
      phase_r <= phase_nxt;
      if (out_space) begin
        out_valid_r <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.action     <= in_tuser[0];
      in_item_r.button     <= in_tdata[4:0];
      in_item_r.left_held  <= in_tdata[5];
      in_item_r.right_held <= in_tdata[6];
    end
    if (load) begin
      out_res_r  <= sel;
      out_last_r <= last_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.timer_cancel, out_res_r.timer_start,
                       out_res_r.button};
  assign out_tuser  = {out_res_r.release_ev, out_res_r.valid};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // The second word of an event only exists while that event is held.
  a_phase_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> in_valid_r)
    else $error("second-result phase without an event in the input register");

  // A held-back press and a fake middle press never coexist.
  a_state_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != BTN_NONE) |-> !fake_r)
    else $error("held-back press while fake middle is down");

  // A word without a pointer event is only the lone timer start.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.valid) |-> (out_res_r.timer_start && out_last_r))
    else $error("empty result word that is not a final timer start");

  // Loading the first of two words moves on to the second one.
  a_two_words: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !phase_r && dec.cnt == 2'd2) |=> phase_r)
    else $error("second result word skipped");
`endif

endmodule
